### rtl/core/dtd_pkg.sv
// shared types, widths and helpers for the date-time difference pipeline
// no dependencies; used by datetime_difference_seconds_unit
package dtd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int DUR_W    = 39;

  // internal widths sized for any 14-bit year and unchecked day/time fields
  localparam int YSUM_W   = 15;  // year plus rounding offset
  localparam int Q4_W     = 13;
  localparam int Q100_W   = 8;
  localparam int LEAPS_W  = 13;
  localparam int DAYS_W   = 23;
  localparam int TOD_W    = 17;
  localparam int DBM_W    = 9;
  localparam int PROD_W   = 40;

  localparam int NUM_LANES = 2;  // lane 0 start, lane 1 end

  // floor(x / 100) as x * 5243 >> 19, exact for x below 43690
  localparam int          DIV100_SHIFT = 19;
  localparam int          DIV100_PW    = 28;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;

  localparam logic [YSUM_W-1:0] OFS_Q4   = 15'd3;
  localparam logic [YSUM_W-1:0] OFS_Q100 = 15'd99;
  localparam logic [YSUM_W-1:0] OFS_Q400 = 15'd399;

  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 23'd365;
  localparam logic [PROD_W-1:0] SECS_PER_DAY  = 40'd86400;
  localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 17'd60;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [Q4_W-1:0]    q4;     // (y+3)/4
    logic [Q100_W-1:0]  qa;     // y/100
    logic [Q100_W-1:0]  qb;     // (y+99)/100
    logic [Q100_W-1:0]  qc;     // (y+399)/100
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TOD_W-1:0]   tod;
  } s1_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } s2_t;

  function automatic logic [Q100_W-1:0] div100(input logic [YSUM_W-1:0] x);
    logic [DIV100_PW-1:0] p;
    p = DIV100_PW'(x) * DIV100_PW'(DIV100_MUL);
    return p[DIV100_SHIFT +: Q100_W];
  endfunction

  // days before the month in a common year; zero reads as january,
  // anything above twelve as december
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/datetime_difference_seconds_unit.sv
// absolute seconds between two gregorian date-times, four register stages
// throughput one word per cycle while out_ready stays high
// stages: leap quotients, day count, scale to seconds, absolute difference
// a stall on out_ready backs up through the stage valid bits, nothing lost or repeated
// reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset
// depends on dtd_pkg
module datetime_difference_seconds_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dtd_pkg::YEAR_W-1:0]      in_start_year,
  input  logic [dtd_pkg::MONTH_W-1:0]     in_start_month,
  input  logic [dtd_pkg::DAY_W-1:0]       in_start_day,
  input  logic [dtd_pkg::HOUR_W-1:0]      in_start_hour,
  input  logic [dtd_pkg::MINUTE_W-1:0]    in_start_minute,
  input  logic [dtd_pkg::SECOND_W-1:0]    in_start_second,
  input  logic [dtd_pkg::YEAR_W-1:0]      in_end_year,
  input  logic [dtd_pkg::MONTH_W-1:0]     in_end_month,
  input  logic [dtd_pkg::DAY_W-1:0]       in_end_day,
  input  logic [dtd_pkg::HOUR_W-1:0]      in_end_hour,
  input  logic [dtd_pkg::MINUTE_W-1:0]    in_end_minute,
  input  logic [dtd_pkg::SECOND_W-1:0]    in_end_second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dtd_pkg::DUR_W-1:0]       out_duration_seconds
);

  localparam int NL = dtd_pkg::NUM_LANES;

  logic [dtd_pkg::YEAR_W-1:0]   yr_in  [NL];
  logic [dtd_pkg::MONTH_W-1:0]  mo_in  [NL];
  logic [dtd_pkg::DAY_W-1:0]    dy_in  [NL];
  logic [dtd_pkg::HOUR_W-1:0]   hr_in  [NL];
  logic [dtd_pkg::MINUTE_W-1:0] mn_in  [NL];
  logic [dtd_pkg::SECOND_W-1:0] sc_in  [NL];

  dtd_pkg::s1_t                 s1_nxt [NL];
  dtd_pkg::s1_t                 s1_r   [NL];
  dtd_pkg::s2_t                 s2_nxt [NL];
  dtd_pkg::s2_t                 s2_r   [NL];
  logic [dtd_pkg::PROD_W-1:0]   prod   [NL];
  logic [dtd_pkg::DUR_W-1:0]    s3_nxt [NL];
  logic [dtd_pkg::DUR_W-1:0]    s3_r   [NL];

  logic                         v1_r, v2_r, v3_r, out_valid_r;
  logic                         en1, en2, en3, en_out;
  logic [dtd_pkg::DUR_W-1:0]    dur_nxt, dur_r;

  assign yr_in[0] = in_start_year;   assign yr_in[1] = in_end_year;
  assign mo_in[0] = in_start_month;  assign mo_in[1] = in_end_month;
  assign dy_in[0] = in_start_day;    assign dy_in[1] = in_end_day;
  assign hr_in[0] = in_start_hour;   assign hr_in[1] = in_end_hour;
  assign mn_in[0] = in_start_minute; assign mn_in[1] = in_end_minute;
  assign sc_in[0] = in_start_second; assign sc_in[1] = in_end_second;

  // a stage loads when it is empty or its word moves on
  assign en_out   = !out_valid_r || out_ready;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    logic [dtd_pkg::YSUM_W-1:0]  ysum;
    logic [dtd_pkg::LEAPS_W-1:0] leaps;
    logic                        leap;
    logic                        leap_adj;

    // stage 1: leap quotients and time of day
    always_comb begin
      ysum             = dtd_pkg::YSUM_W'(yr_in[g]);
      s1_nxt[g].year   = yr_in[g];
      s1_nxt[g].q4     = dtd_pkg::Q4_W'((ysum + dtd_pkg::OFS_Q4) >> 2);
      s1_nxt[g].qa     = dtd_pkg::div100(ysum);
      s1_nxt[g].qb     = dtd_pkg::div100(ysum + dtd_pkg::OFS_Q100);
      s1_nxt[g].qc     = dtd_pkg::div100(ysum + dtd_pkg::OFS_Q400);
      s1_nxt[g].month  = mo_in[g];
      s1_nxt[g].day    = dy_in[g];
      s1_nxt[g].tod    = dtd_pkg::TOD_W'(hr_in[g]) * dtd_pkg::SECS_PER_HOUR
                       + dtd_pkg::TOD_W'(mn_in[g]) * dtd_pkg::SECS_PER_MIN
                       + dtd_pkg::TOD_W'(sc_in[g]);
    end

    // stage 2: day count; (y+399)/400 is the /100 quotient shifted by two
    always_comb begin
      leaps = s1_r[g].q4 - dtd_pkg::LEAPS_W'(s1_r[g].qb)
            + dtd_pkg::LEAPS_W'(s1_r[g].qc >> 2);
      leap  = (s1_r[g].year[1:0] == 2'b00) &&
              ((dtd_pkg::YSUM_W'(s1_r[g].qa) * dtd_pkg::YSUM_W'(100)
                != dtd_pkg::YSUM_W'(s1_r[g].year)) || (s1_r[g].qa[1:0] == 2'b00));
      leap_adj = leap && (s1_r[g].month > dtd_pkg::MONTH_W'(2));
      s2_nxt[g].days = dtd_pkg::DAYS_W'(s1_r[g].year) * dtd_pkg::DAYS_PER_YEAR
                     + dtd_pkg::DAYS_W'(leaps)
                     + dtd_pkg::DAYS_W'(dtd_pkg::days_before_month(s1_r[g].month))
                     + dtd_pkg::DAYS_W'(leap_adj)
                     + dtd_pkg::DAYS_W'(s1_r[g].day);
      s2_nxt[g].tod  = s1_r[g].tod;
    end

    // stage 3: scale to seconds
    always_comb begin
      prod[g]   = dtd_pkg::PROD_W'(s2_r[g].days) * dtd_pkg::SECS_PER_DAY;
      s3_nxt[g] = prod[g][dtd_pkg::DUR_W-1:0] + dtd_pkg::DUR_W'(s2_r[g].tod);
    end

    always_ff @(posedge clk) begin
      if (en1) begin
        s1_r[g] <= s1_nxt[g];
      end
      if (en2) begin
        s2_r[g] <= s2_nxt[g];
      end
      if (en3) begin
        s3_r[g] <= s3_nxt[g];
      end
    end
  end

  // stage 4: absolute difference
  always_comb begin
    if (s3_r[1] >= s3_r[0]) begin
      dur_nxt = s3_r[1] - s3_r[0];
    end else begin
      dur_nxt = s3_r[0] - s3_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      dur_r <= dur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_duration_seconds = dur_r;

  // an empty output register lets the whole pipe advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low with empty output register");

  // a word leaving the last stage lands in the output register
  a_stage3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en_out) |=> out_valid_r)
    else $error("word lost between stage 3 and output");

  // full pipe with a stalled output must not take a new word
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted into a full stalled pipe");

  // scaled seconds never reach the top product bit
  a_secs_fit: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (!prod[0][dtd_pkg::PROD_W-1] && !prod[1][dtd_pkg::PROD_W-1]))
    else $error("seconds product overflows duration width");

endmodule

### verif/datetime_difference_seconds_unit_test.sv
// self-checking bench for datetime_difference_seconds_unit: directed and random date-time pairs
// queue-fed driver, bursty sender, patterned receiver, in-order duration scoreboard
// depends on dtd_pkg and the datetime_difference_seconds_unit rtl
`timescale 1ns / 100ps

module datetime_difference_seconds_unit_test;

  localparam int RANDOM_PAIRS = 1750;

  typedef struct packed {
    logic [dtd_pkg::YEAR_W-1:0]   year;
    logic [dtd_pkg::MONTH_W-1:0]  month;
    logic [dtd_pkg::DAY_W-1:0]    day;
    logic [dtd_pkg::HOUR_W-1:0]   hour;
    logic [dtd_pkg::MINUTE_W-1:0] minute;
    logic [dtd_pkg::SECOND_W-1:0] second;
  } stamp_t;

  typedef struct packed {
    stamp_t from_ts;
    stamp_t to_ts;
    bit     drain_first;  // hold this word back until every duration is back
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [dtd_pkg::YEAR_W-1:0]   in_start_year = '0;
  logic [dtd_pkg::MONTH_W-1:0]  in_start_month = '0;
  logic [dtd_pkg::DAY_W-1:0]    in_start_day = '0;
  logic [dtd_pkg::HOUR_W-1:0]   in_start_hour = '0;
  logic [dtd_pkg::MINUTE_W-1:0] in_start_minute = '0;
  logic [dtd_pkg::SECOND_W-1:0] in_start_second = '0;
  logic [dtd_pkg::YEAR_W-1:0]   in_end_year = '0;
  logic [dtd_pkg::MONTH_W-1:0]  in_end_month = '0;
  logic [dtd_pkg::DAY_W-1:0]    in_end_day = '0;
  logic [dtd_pkg::HOUR_W-1:0]   in_end_hour = '0;
  logic [dtd_pkg::MINUTE_W-1:0] in_end_minute = '0;
  logic [dtd_pkg::SECOND_W-1:0] in_end_second = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [dtd_pkg::DUR_W-1:0]    out_duration_seconds;

  pair_t                     pending_pairs[$];
  logic [dtd_pkg::DUR_W-1:0] expected_durations[$];
  logic                      in_taken = 1'b0;
  int                        pairs_accepted = 0;
  int                        fail_count = 0;

  datetime_difference_seconds_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_start_year        (in_start_year),
    .in_start_month       (in_start_month),
    .in_start_day         (in_start_day),
    .in_start_hour        (in_start_hour),
    .in_start_minute      (in_start_minute),
    .in_start_second      (in_start_second),
    .in_end_year          (in_end_year),
    .in_end_month         (in_end_month),
    .in_end_day           (in_end_day),
    .in_end_hour          (in_end_hour),
    .in_end_minute        (in_end_minute),
    .in_end_second        (in_end_second),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_duration_seconds (out_duration_seconds)
  );

  always #6 clk = ~clk;

  // seconds counted from day zero of year zero, year zero being leap
  function automatic longint unsigned seconds_from_year_zero(stamp_t s);
    longint unsigned y;
    longint unsigned days;
    longint unsigned tod;
    int unsigned     m;
    bit              leap;
    y = 64'(s.year);
    m = 32'(s.month);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    case (m)
      1:  days += 0;
      2:  days += 31;
      3:  days += 59;
      4:  days += 90;
      5:  days += 120;
      6:  days += 151;
      7:  days += 181;
      8:  days += 212;
      9:  days += 243;
      10: days += 273;
      11: days += 304;
      default: days += 334;
    endcase
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m > 2 && leap) days += 1;
    days += longint'(s.day);
    tod = longint'(s.hour) * 3600 + longint'(s.minute) * 60 + longint'(s.second);
    return days * 86400 + tod;
  endfunction

  function automatic logic [dtd_pkg::DUR_W-1:0] duration_between(stamp_t a, stamp_t b);
    longint unsigned sa;
    longint unsigned sb;
    sa = seconds_from_year_zero(a);
    sb = seconds_from_year_zero(b);
    return (sb >= sa) ? dtd_pkg::DUR_W'(sb - sa) : dtd_pkg::DUR_W'(sa - sb);
  endfunction

  function automatic stamp_t mk(int y, int mo, int d, int h, int mi, int s);
    stamp_t t;
    t.year = dtd_pkg::YEAR_W'(y);
    t.month = dtd_pkg::MONTH_W'(mo);
    t.day = dtd_pkg::DAY_W'(d);
    t.hour = dtd_pkg::HOUR_W'(h);
    t.minute = dtd_pkg::MINUTE_W'(mi);
    t.second = dtd_pkg::SECOND_W'(s);
    return t;
  endfunction

  // mostly legal stamps; now and then full-width fields or a century year
  function automatic stamp_t random_stamp();
    stamp_t s;
    bit     wild;
    wild = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 7) == 0)
      s.year = dtd_pkg::YEAR_W'($urandom_range(0, 99) * 100 + $urandom_range(0, 1) * 4);
    else
      s.year = dtd_pkg::YEAR_W'(wild ? $urandom_range(0, 16383) : $urandom_range(0, 9999));
    s.month  = dtd_pkg::MONTH_W'(wild ? $urandom_range(0, 15) : $urandom_range(1, 12));
    s.day    = dtd_pkg::DAY_W'(wild ? $urandom_range(0, 31) : $urandom_range(1, 31));
    s.hour   = dtd_pkg::HOUR_W'(wild ? $urandom_range(0, 31) : $urandom_range(0, 23));
    s.minute = dtd_pkg::MINUTE_W'(wild ? $urandom_range(0, 63) : $urandom_range(0, 59));
    s.second = dtd_pkg::SECOND_W'(wild ? $urandom_range(0, 63) : $urandom_range(0, 59));
    return s;
  endfunction

  function automatic pair_t random_pair();
    pair_t  p;
    stamp_t other;
    p.drain_first = 1'b0;
    p.from_ts = random_stamp();
    if ($urandom_range(0, 2) == 0) begin
      // nearby stamps: borrow a few fields from a fresh one
      other = random_stamp();
      p.to_ts = p.from_ts;
      if ($urandom_range(0, 2) == 0)
        p.to_ts.year = dtd_pkg::YEAR_W'(32'(p.from_ts.year) + $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) p.to_ts.month = other.month;
      if ($urandom_range(0, 2) == 0) p.to_ts.day = other.day;
      if ($urandom_range(0, 2) == 0) p.to_ts.hour = other.hour;
      if ($urandom_range(0, 2) == 0) p.to_ts.minute = other.minute;
      if ($urandom_range(0, 2) == 0) p.to_ts.second = other.second;
    end else begin
      p.to_ts = random_stamp();
    end
    return p;
  endfunction

  task automatic add_pair(stamp_t a, stamp_t b);
    pair_t p;
    p.from_ts = a;
    p.to_ts = b;
    p.drain_first = 1'b0;
    pending_pairs.push_back(p);
  endtask

  // sender: bursts of words with random gaps
  int gap_left = 0;
  int burst_left = 8;

  always @(negedge clk) begin : sender
    pair_t p;
    if (!rst_n || (in_valid && !in_taken)) begin
      // reset, or a word still waiting: hold everything
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_pairs.size() != 0 &&
                 !(pending_pairs[0].drain_first && expected_durations.size() != 0)) begin
      p = pending_pairs.pop_front();
      in_start_year   <= p.from_ts.year;
      in_start_month  <= p.from_ts.month;
      in_start_day    <= p.from_ts.day;
      in_start_hour   <= p.from_ts.hour;
      in_start_minute <= p.from_ts.minute;
      in_start_second <= p.from_ts.second;
      in_end_year     <= p.to_ts.year;
      in_end_month    <= p.to_ts.month;
      in_end_day      <= p.to_ts.day;
      in_end_hour     <= p.to_ts.hour;
      in_end_minute   <= p.to_ts.minute;
      in_end_second   <= p.to_ts.second;
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 60);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: modes of random length, plus two long hold-offs to back up the pipe
  int rx_mode = 0;
  int rx_mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 400;

  always @(negedge clk) begin : receiver
    bit rdy;
    if (next_hold_at > 0 && pairs_accepted >= next_hold_at) begin
      hold_left = 300;
      next_hold_at = (next_hold_at == 400) ? 1300 : 0;
    end
    if (rx_mode_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(16, 200);
    end
    rx_mode_left--;
    if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ~out_ready;
      endcase
    end
    out_ready <= rdy;
  end

  // scoreboard: predict on input accept, compare on output accept
  always @(posedge clk) begin : scoreboard
    stamp_t                    a;
    stamp_t                    b;
    logic [dtd_pkg::DUR_W-1:0] want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        a = '{in_start_year, in_start_month, in_start_day,
              in_start_hour, in_start_minute, in_start_second};
        b = '{in_end_year, in_end_month, in_end_day,
              in_end_hour, in_end_minute, in_end_second};
        expected_durations.push_back(duration_between(a, b));
        pairs_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_durations.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual duration_seconds %0d",
                   $time, out_duration_seconds);
        end else begin
          want = expected_durations.pop_front();
          if (out_duration_seconds !== want) begin
            fail_count++;
            $display("%0t: duration_seconds mismatch, expected %0d, actual %0d",
                     $time, want, out_duration_seconds);
          end
        end
      end
    end
  end

  initial begin : stimulus
    pair_t p;
    // extremes and full-width fields
    add_pair(mk(0, 1, 1, 0, 0, 0), mk(0, 1, 1, 0, 0, 0));
    add_pair(mk(0, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59));
    add_pair(mk(16383, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0));
    add_pair(mk(0, 0, 0, 0, 0, 0), mk(16383, 15, 31, 31, 63, 63));
    // month zero behaves as january, above twelve as december
    add_pair(mk(2021, 0, 10, 5, 6, 7), mk(2021, 1, 10, 5, 6, 7));
    add_pair(mk(2021, 13, 1, 0, 0, 0), mk(2021, 12, 1, 0, 0, 0));
    add_pair(mk(2020, 15, 31, 0, 0, 0), mk(2020, 3, 1, 0, 0, 0));
    // unchecked days: zero and past month end
    add_pair(mk(2019, 2, 0, 0, 0, 0), mk(2019, 2, 31, 0, 0, 0));
    add_pair(mk(2019, 4, 31, 12, 0, 0), mk(2019, 5, 1, 12, 0, 0));
    // leap rule across february
    add_pair(mk(2000, 2, 29, 0, 0, 0), mk(2000, 3, 1, 0, 0, 0));
    add_pair(mk(1900, 2, 28, 0, 0, 0), mk(1900, 3, 1, 0, 0, 0));
    add_pair(mk(2004, 2, 28, 23, 59, 59), mk(2004, 3, 1, 0, 0, 0));
    add_pair(mk(2100, 1, 1, 0, 0, 0), mk(2101, 1, 1, 0, 0, 0));
    add_pair(mk(0, 3, 1, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
    add_pair(mk(399, 12, 31, 0, 0, 0), mk(401, 1, 1, 0, 0, 0));
    add_pair(mk(100, 6, 15, 1, 2, 3), mk(400, 6, 15, 1, 2, 3));
    // time-of-day out of range, start after end, equal stamps, years past 9999, a month change
    add_pair(mk(2022, 7, 4, 31, 63, 63), mk(2022, 7, 4, 0, 0, 0));
    add_pair(mk(2023, 9, 1, 0, 0, 1), mk(2023, 9, 1, 0, 0, 0));
    add_pair(mk(9999, 12, 31, 23, 59, 59), mk(9999, 12, 31, 23, 59, 59));
    add_pair(mk(10000, 1, 1, 0, 0, 0), mk(16383, 12, 31, 23, 59, 59));
    add_pair(mk(5000, 10, 31, 0, 0, 0), mk(5000, 11, 1, 0, 0, 0));
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      p = random_pair();
      // let the pipe empty before the random part and once midway
      p.drain_first = (i == 0) || (i == 900);
      pending_pairs.push_back(p);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid) @(negedge clk);
    while (expected_durations.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
